@@ design/genotype_pair_mismatch_counter_core_macros.svh @@
// Assertion macros for the genotype pair mismatch counter.
// Included by the RTL file that carries concurrent checks; no other dependencies.
`ifndef GENOTYPE_PAIR_MISMATCH_COUNTER_CORE_MACROS_SVH
`define GENOTYPE_PAIR_MISMATCH_COUNTER_CORE_MACROS_SVH

`ifndef SYNTH

// Clocked check, masked while reset is asserted
`define GPMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define GPMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GPMC_ASSERT(lbl, prop, msg)
`define GPMC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/gpmc_pkg.sv @@
// Shared constants and types for the genotype pair mismatch counter.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps
`default_nettype none

package gpmc_pkg;

    // Field widths
    localparam int ALLELE_W       = 8;
    localparam int CODE_W         = 2;
    localparam int OUT_W          = 32;
    localparam int NUM_CNT        = 6;
    localparam int DEF_COUNT_BITS = 32;

    // Largest legal allele code
    localparam logic [CODE_W-1:0] MAX_CODE = 2'd3;

    // Counter slots
    localparam int CNT_VALID    = 0;
    localparam int CNT_MISMATCH = 1;
    localparam int CNT_HOMHOM   = 2;
    localparam int CNT_OVERLAP  = 3;
    localparam int CNT_DISJOINT = 4;
    localparam int CNT_HETHET   = 5;

    // Per-site increment flags from the classifier
    typedef struct packed {
        logic valid;
        logic mismatch;
        logic homhom;
        logic overlap;
        logic disjoint;
        logic hethet;
    } site_flags_t;

    typedef logic [NUM_CNT-1:0][OUT_W-1:0] count_vec_t;

endpackage

`default_nettype wire

@@ design/gpmc_if.sv @@
// Valid/ready channel interfaces: site words in, count words out.
// Depends on gpmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gpmc_site_if;
    import gpmc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ALLELE_W-1:0] first_a;
    logic signed [ALLELE_W-1:0] second_a;
    logic signed [ALLELE_W-1:0] first_b;
    logic signed [ALLELE_W-1:0] second_b;
    logic                       end_of_pair;

    modport source (output valid, first_a, second_a, first_b, second_b, end_of_pair,
                    input ready);
    modport sink   (input valid, first_a, second_a, first_b, second_b, end_of_pair,
                    output ready);
endinterface

interface gpmc_result_if;
    import gpmc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] valid_sites;
    logic [OUT_W-1:0] mismatched_sites;
    logic [OUT_W-1:0] hom_hom_count;
    logic [OUT_W-1:0] het_hom_overlap_count;
    logic [OUT_W-1:0] het_hom_disjoint_count;
    logic [OUT_W-1:0] het_het_count;

    modport source (output valid, valid_sites, mismatched_sites, hom_hom_count,
                    het_hom_overlap_count, het_hom_disjoint_count, het_het_count,
                    input ready);
    modport sink   (input valid, valid_sites, mismatched_sites, hom_hom_count,
                    het_hom_overlap_count, het_hom_disjoint_count, het_het_count,
                    output ready);
endinterface

`default_nettype wire

@@ design/gpmc_classify.sv @@
// Site classifier: range check, pair ordering and mismatch class flags.
// Pure combinational; depends on gpmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpmc_classify (
    input  wire logic signed [gpmc_pkg::ALLELE_W-1:0] first_a,
    input  wire logic signed [gpmc_pkg::ALLELE_W-1:0] second_a,
    input  wire logic signed [gpmc_pkg::ALLELE_W-1:0] first_b,
    input  wire logic signed [gpmc_pkg::ALLELE_W-1:0] second_b,
    output gpmc_pkg::site_flags_t                     flags
);
    import gpmc_pkg::*;

    logic              in_range;
    logic [CODE_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic              a_hom, b_hom, differ;
    logic              homhom, overlap;

    // All four codes must be 0..3; negatives have the upper bits set
    always_comb
    begin
        in_range = (first_a[ALLELE_W-1:CODE_W] == '0)
                && (second_a[ALLELE_W-1:CODE_W] == '0)
                && (first_b[ALLELE_W-1:CODE_W] == '0)
                && (second_b[ALLELE_W-1:CODE_W] == '0)
                && (first_a[CODE_W-1:0] <= MAX_CODE);
    end

    // Order each pair ascending
    always_comb
    begin
        if (first_a[CODE_W-1:0] > second_a[CODE_W-1:0])
        begin
            a_lo = second_a[CODE_W-1:0];
            a_hi = first_a[CODE_W-1:0];
        end
        else
        begin
            a_lo = first_a[CODE_W-1:0];
            a_hi = second_a[CODE_W-1:0];
        end
        if (first_b[CODE_W-1:0] > second_b[CODE_W-1:0])
        begin
            b_lo = second_b[CODE_W-1:0];
            b_hi = first_b[CODE_W-1:0];
        end
        else
        begin
            b_lo = first_b[CODE_W-1:0];
            b_hi = second_b[CODE_W-1:0];
        end
    end

    // Mismatch class in priority order
    always_comb
    begin
        a_hom   = (a_lo == a_hi);
        b_hom   = (b_lo == b_hi);
        differ  = !((a_lo == b_lo) && (a_hi == b_hi));
        homhom  = a_hom && b_hom;
        overlap = !homhom
               && ((a_hom && ((a_lo == b_lo) || (a_lo == b_hi)))
               ||  (b_hom && ((b_lo == a_lo) || (b_lo == a_hi))));

        flags.valid    = in_range;
        flags.mismatch = in_range && differ;
        flags.homhom   = in_range && differ && homhom;
        flags.overlap  = in_range && differ && overlap;
        flags.disjoint = in_range && differ && !homhom && !overlap && (a_hom || b_hom);
        flags.hethet   = in_range && differ && !a_hom && !b_hom;
    end

endmodule

`default_nettype wire

@@ design/gpmc_counters.sv @@
// Six saturating site counters with clear-on-last and 32-bit emit values.
// Depends on gpmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpmc_counters #(
    parameter int COUNT_BITS = gpmc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  last,
    input  wire gpmc_pkg::site_flags_t flags,
    output gpmc_pkg::count_vec_t       emit
);
    import gpmc_pkg::*;

    localparam int EXT_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W + 1;

    logic [NUM_CNT-1:0]                 inc;
    logic [NUM_CNT-1:0][COUNT_BITS-1:0] acc_reg;
    logic [NUM_CNT-1:0][COUNT_BITS-1:0] acc_next;
    logic [NUM_CNT-1:0][COUNT_BITS-1:0] bumped;
    logic [NUM_CNT-1:0][EXT_W-1:0]      wide;

    // Map classifier flags to counter slots
    always_comb
    begin
        inc               = '0;
        inc[CNT_VALID]    = flags.valid;
        inc[CNT_MISMATCH] = flags.mismatch;
        inc[CNT_HOMHOM]   = flags.homhom;
        inc[CNT_OVERLAP]  = flags.overlap;
        inc[CNT_DISJOINT] = flags.disjoint;
        inc[CNT_HETHET]   = flags.hethet;
    end

    // Saturating increment, clear after the last site, clamp for emit
    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
        begin
            if (inc[i] && !(&acc_reg[i]))
                bumped[i] = acc_reg[i] + COUNT_BITS'(1);
            else
                bumped[i] = acc_reg[i];
            acc_next[i] = last ? '0 : bumped[i];
            wide[i]     = EXT_W'(bumped[i]);
            if (|wide[i][EXT_W-1:OUT_W])
                emit[i] = '1;
            else
                emit[i] = wide[i][OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (step)
            acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

@@ design/genotype_pair_mismatch_counter_core.sv @@
// Genotype pair mismatch counter. A site word is captured in the input register,
// then classified and counted from it; a final site's counts are loaded into the
// result register that drives the result port. Throughput: one site word per cycle,
// set by the input register and the counter update; a final site stalls only while
// the result register is still full. Reset clears all counters and valid flags.
`timescale 1ns / 1ps
`default_nettype none

`include "genotype_pair_mismatch_counter_core_macros.svh"

module genotype_pair_mismatch_counter_core #(
    parameter int COUNT_BITS = gpmc_pkg::DEF_COUNT_BITS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    gpmc_site_if.sink      site,
    gpmc_result_if.source  result
);
    import gpmc_pkg::*;

    // Input register
    logic                       s1_valid_reg;
    logic signed [ALLELE_W-1:0] s1_first_a_reg, s1_second_a_reg;
    logic signed [ALLELE_W-1:0] s1_first_b_reg, s1_second_b_reg;
    logic                       s1_last_reg;

    // Result register
    logic       out_valid_reg;
    count_vec_t out_reg;

    logic        out_free, s1_go, site_take;
    site_flags_t flags;
    count_vec_t  emit;

    // Handshake: a final site moves only when the result slot is free
    assign out_free  = !out_valid_reg || result.ready;
    assign s1_go     = s1_valid_reg && (!s1_last_reg || out_free);
    assign site.ready = !s1_valid_reg || s1_go;
    assign site_take = site.valid && site.ready;

    // Input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (site.ready)
            s1_valid_reg <= site.valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (site_take)
        begin
            s1_first_a_reg  <= site.first_a;
            s1_second_a_reg <= site.second_a;
            s1_first_b_reg  <= site.first_b;
            s1_second_b_reg <= site.second_b;
            s1_last_reg     <= site.end_of_pair;
        end
    end

    gpmc_classify u_classify (
        .first_a  (s1_first_a_reg),
        .second_a (s1_second_a_reg),
        .first_b  (s1_first_b_reg),
        .second_b (s1_second_b_reg),
        .flags    (flags)
    );

    gpmc_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_go),
        .last  (s1_last_reg),
        .flags (flags),
        .emit  (emit)
    );

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
            out_reg <= emit;
    end

    assign result.valid                  = out_valid_reg;
    assign result.valid_sites            = out_reg[CNT_VALID];
    assign result.mismatched_sites       = out_reg[CNT_MISMATCH];
    assign result.hom_hom_count          = out_reg[CNT_HOMHOM];
    assign result.het_hom_overlap_count  = out_reg[CNT_OVERLAP];
    assign result.het_hom_disjoint_count = out_reg[CNT_DISJOINT];
    assign result.het_het_count          = out_reg[CNT_HETHET];

    // Checks
    `GPMC_ASSERT(a_last_makes_result, (s1_go && s1_last_reg) |=> out_valid_reg,
                 "final site did not load the result register")
    `GPMC_ASSERT(a_stalled_last_held, (s1_valid_reg && !s1_go) |=> s1_valid_reg,
                 "stalled final site was dropped")
    `GPMC_ASSERT(a_empty_stage_ready, !s1_valid_reg |-> site.ready,
                 "empty input stage refused a word")
    `GPMC_ASSERT(a_mismatch_le_valid,
                 out_valid_reg |-> (out_reg[CNT_MISMATCH] <= out_reg[CNT_VALID]),
                 "mismatch count exceeds valid count")
    // flags are checked on the edge after reset is sampled, once the async clear has landed
    `GPMC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_reg && !s1_valid_reg),
                        "valid flags not cleared in reset")

endmodule

`default_nettype wire
